// ===== rtl/core/aarch64_relocation_patcher_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the relocation patcher
// Each macro expects signals named clk and arst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef AARCH64_RELOCATION_PATCHER_MACROS_SVH
`define AARCH64_RELOCATION_PATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("relocation patcher check failed");

// Consequent must hold in the cycle after the antecedent.
`define RP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("relocation patcher check failed");

`endif

// ===== rtl/core/relpat_pkg.sv =====
// ---------------------------------------------------------------------------
// relpat_pkg
// Types, relocation type numbers and the type decoder for the patcher.
// ---------------------------------------------------------------------------
package relpat_pkg;

	// AArch64 ELF relocation type numbers
	localparam logic [31:0] R_ABS64     = 32'd257;
	localparam logic [31:0] R_ABS32     = 32'd258;
	localparam logic [31:0] R_ABS16     = 32'd259;
	localparam logic [31:0] R_PREL64    = 32'd260;
	localparam logic [31:0] R_PREL32    = 32'd261;
	localparam logic [31:0] R_PREL16    = 32'd262;
	localparam logic [31:0] R_ADR_PG    = 32'd275;
	localparam logic [31:0] R_ADD_LO12  = 32'd277;
	localparam logic [31:0] R_JUMP26    = 32'd282;
	localparam logic [31:0] R_CALL26    = 32'd283;
	localparam logic [31:0] R_JUMP_SLOT = 32'd1026;
	localparam logic [31:0] R_RELATIVE  = 32'd1027;

	// Store sizes
	localparam logic [3:0] BYTES_NONE = 4'd0;
	localparam logic [3:0] BYTES_HALF = 4'd2;
	localparam logic [3:0] BYTES_WORD = 4'd4;
	localparam logic [3:0] BYTES_DBL  = 4'd8;

	// Instruction field masks (bits kept from the old word)
	localparam logic [31:0] IMM26_KEEP = 32'hFC00_0000;
	localparam logic [31:0] ADR_KEEP   = 32'h9F00_001F;
	localparam logic [31:0] ADD_KEEP   = 32'hFFC0_03FF;

	// Decoded relocation class
	typedef enum logic [3:0] {
		CLS_ABS64,
		CLS_ABS32,
		CLS_ABS16,
		CLS_PREL64,
		CLS_PREL32,
		CLS_PREL16,
		CLS_BRANCH26,
		CLS_ADR_PG,
		CLS_ADD_LO12,
		CLS_BAD
	} rel_cls_t;

	function automatic rel_cls_t decode_type(input logic [31:0] mode);
		rel_cls_t cls;
		unique case (mode) inside
			R_ABS64, R_JUMP_SLOT, R_RELATIVE: cls = CLS_ABS64;
			R_ABS32:                          cls = CLS_ABS32;
			R_ABS16:                          cls = CLS_ABS16;
			R_PREL64:                         cls = CLS_PREL64;
			R_PREL32:                         cls = CLS_PREL32;
			R_PREL16:                         cls = CLS_PREL16;
			R_JUMP26, R_CALL26:               cls = CLS_BRANCH26;
			R_ADR_PG:                         cls = CLS_ADR_PG;
			R_ADD_LO12:                       cls = CLS_ADD_LO12;
			default:                          cls = CLS_BAD;
		endcase
		return cls;
	endfunction

endpackage

// ===== rtl/core/relpat_if.sv =====
// ---------------------------------------------------------------------------
// relpat_if
// Valid/ready channels for relocation entries and patch results.
// ---------------------------------------------------------------------------
interface relpat_reloc_if;
	logic               valid;
	logic               ready;
	logic        [31:0] mode;
	logic        [63:0] symbol_value;
	logic        [63:0] place_offset;
	logic signed [63:0] addend;
	logic        [31:0] old_word;

	modport source (output valid, mode, symbol_value, place_offset, addend, old_word,
		input ready);
	modport sink (input valid, mode, symbol_value, place_offset, addend, old_word,
		output ready);
endinterface

interface relpat_patch_if;
	logic        valid;
	logic        ready;
	logic [63:0] store_value;
	logic  [3:0] store_bytes;
	logic        unhandled;

	modport source (output valid, store_value, store_bytes, unhandled, input ready);
	modport sink (input valid, store_value, store_bytes, unhandled, output ready);
endinterface

// ===== rtl/core/relpat_prep.sv =====
// ---------------------------------------------------------------------------
// relpat_prep
// Front half of the compute path: S+A, place address and relocation type decode.
// ---------------------------------------------------------------------------
module relpat_prep (
	input  logic               [31:0] mode,
	input  logic               [63:0] symbol_value,
	input  logic               [63:0] place_offset,
	input  logic signed        [63:0] addend,
	input  logic               [63:0] load_base,
	output relpat_pkg::rel_cls_t      cls,
	output logic               [63:0] sa,
	output logic               [63:0] place
);
	import relpat_pkg::*;

	// Two independent 64-bit adds, modulo 2^64
	assign sa    = symbol_value + $unsigned(addend);
	assign place = load_base + place_offset;
	assign cls   = decode_type(mode);

endmodule

// ===== rtl/core/relpat_fmt.sv =====
// ---------------------------------------------------------------------------
// relpat_fmt
// Back half of the compute path: PC-relative delta and store value formatting.
// ---------------------------------------------------------------------------
module relpat_fmt (
	input  relpat_pkg::rel_cls_t      cls,
	input  logic               [63:0] sa,
	input  logic               [63:0] place,
	input  logic               [31:0] old_word,
	output logic               [63:0] store_value,
	output logic                [3:0] store_bytes,
	output logic                      unhandled
);
	import relpat_pkg::*;

	logic [63:0] rel;
	logic [20:0] imm21;
	logic [31:0] br_word;
	logic [31:0] adr_word;
	logic [31:0] add_word;

	// S+A-P, and the page delta bits 32:12 (low page bits cannot borrow)
	assign rel   = sa - place;
	assign imm21 = sa[32:12] - place[32:12];

	// Instruction field inserts
	assign br_word  = (old_word & IMM26_KEEP) | {6'd0, rel[27:2]};
	assign adr_word = (old_word & ADR_KEEP) | {1'b0, imm21[1:0], 5'd0, imm21[20:2], 5'd0};
	assign add_word = (old_word & ADD_KEEP) | {10'd0, sa[11:0], 10'd0};

	// Result select
	always_comb begin
		store_value = '0;
		store_bytes = BYTES_NONE;
		unhandled   = 1'b0;
		case (cls)
			CLS_ABS64: begin
				store_value = sa;
				store_bytes = BYTES_DBL;
			end
			CLS_ABS32: begin
				store_value = {32'd0, sa[31:0]};
				store_bytes = BYTES_WORD;
			end
			CLS_ABS16: begin
				store_value = {48'd0, sa[15:0]};
				store_bytes = BYTES_HALF;
			end
			CLS_PREL64: begin
				store_value = rel;
				store_bytes = BYTES_DBL;
			end
			CLS_PREL32: begin
				store_value = {32'd0, rel[31:0]};
				store_bytes = BYTES_WORD;
			end
			CLS_PREL16: begin
				store_value = {48'd0, rel[15:0]};
				store_bytes = BYTES_HALF;
			end
			CLS_BRANCH26: begin
				store_value = {32'd0, br_word};
				store_bytes = BYTES_WORD;
			end
			CLS_ADR_PG: begin
				store_value = {32'd0, adr_word};
				store_bytes = BYTES_WORD;
			end
			CLS_ADD_LO12: begin
				store_value = {32'd0, add_word};
				store_bytes = BYTES_WORD;
			end
			default: begin
				unhandled = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/core/aarch64_relocation_patcher.sv =====
// ---------------------------------------------------------------------------
// aarch64_relocation_patcher
// Applies one AArch64 ELF relocation per transaction.
//
//   channel    dir   payload
//   reloc      in    mode, symbol_value, place_offset, addend, old_word
//   patch      out   store_value, store_bytes, unhandled
//   load_base  in    load_base_we, load_base_wdata (write only)
//
// Two register stages: input capture, then formatted result; sum, place,
// decode and formatting sit between them. One transaction per cycle while
// patch.ready holds; patch.valid rises when the result register loads. Each
// stage advances when the next is empty or moving; a sink stall holds two
// transactions before reloc.ready drops. arst_n clears the valids and load_base.
// ---------------------------------------------------------------------------
module aarch64_relocation_patcher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_base_we,
	input  logic    [63:0] load_base_wdata,
	relpat_reloc_if.sink   reloc,
	relpat_patch_if.source patch
);
	import relpat_pkg::*;

	logic [63:0] load_base_q;

	logic               v_s1, v_s2;
	logic               en_s1, en_s2;
	logic        [31:0] mode_s1;
	logic        [63:0] sym_s1;
	logic        [63:0] off_s1;
	logic signed [63:0] addend_s1;
	logic        [31:0] word_s1;

	logic [63:0] value_s2;
	logic  [3:0] bytes_s2;
	logic        bad_s2;

	rel_cls_t    cls_c;
	logic [63:0] sa_c;
	logic [63:0] place_c;
	logic [63:0] value_c;
	logic  [3:0] bytes_c;
	logic        bad_c;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= '0;
		end else if (load_base_we) begin
			load_base_q <= load_base_wdata;
		end
	end

	// Stage enables, back to front
	assign en_s2       = !v_s2 || patch.ready;
	assign en_s1       = !v_s1 || en_s2;
	assign reloc.ready = en_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= reloc.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (en_s1 && reloc.valid) begin
			mode_s1   <= reloc.mode;
			sym_s1    <= reloc.symbol_value;
			off_s1    <= reloc.place_offset;
			addend_s1 <= reloc.addend;
			word_s1   <= reloc.old_word;
		end
	end

	relpat_prep u_prep (
		.mode         (mode_s1),
		.symbol_value (sym_s1),
		.place_offset (off_s1),
		.addend       (addend_s1),
		.load_base    (load_base_q),
		.cls          (cls_c),
		.sa           (sa_c),
		.place        (place_c)
	);

	relpat_fmt u_fmt (
		.cls         (cls_c),
		.sa          (sa_c),
		.place       (place_c),
		.old_word    (word_s1),
		.store_value (value_c),
		.store_bytes (bytes_c),
		.unhandled   (bad_c)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			value_s2 <= value_c;
			bytes_s2 <= bytes_c;
			bad_s2   <= bad_c;
		end
	end

	assign patch.valid       = v_s2;
	assign patch.store_value = value_s2;
	assign patch.store_bytes = bytes_s2;
	assign patch.unhandled   = bad_s2;

endmodule

// ===== rtl/core/relpat_checker.sv =====
// ---------------------------------------------------------------------------
// relpat_checker
// Port-level checks on the patch results, bound to the top level.
// ---------------------------------------------------------------------------
`include "aarch64_relocation_patcher_macros.svh"

module relpat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] store_value,
	input logic  [3:0] store_bytes,
	input logic        unhandled
);
	import relpat_pkg::*;

	// Unsupported types store nothing
	`RP_ASSERT_SAME(a_bad_empty, out_valid && unhandled,
		store_bytes == BYTES_NONE && store_value == 64'd0)

	// Supported types use one of the three store sizes
	`RP_ASSERT_SAME(a_size_legal, out_valid && !unhandled,
		store_bytes == BYTES_HALF || store_bytes == BYTES_WORD || store_bytes == BYTES_DBL)

	// Bytes above the store size are zero
	`RP_ASSERT_SAME(a_upper_zero, out_valid && store_bytes != BYTES_DBL,
		store_value[63:32] == 32'd0 && (store_bytes != BYTES_HALF || store_value[31:16] == 16'd0))

	// A stalled result holds
	`RP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(store_value) && $stable(store_bytes) && $stable(unhandled))

endmodule

bind aarch64_relocation_patcher relpat_checker u_relpat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (patch.valid),
	.out_ready   (patch.ready),
	.store_value (patch.store_value),
	.store_bytes (patch.store_bytes),
	.unhandled   (patch.unhandled)
);

// ===== test/tb_aarch64_relocation_patcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aarch64_relocation_patcher
// Drives relocation entries through the patcher under random source gaps,
// sink stalls and two long sink hold-offs, over several load_base settings.
// Each patch transaction is checked field by field against a local
// computation of the AArch64 relocation formulas.
// ---------------------------------------------------------------------------
module tb_aarch64_relocation_patcher;
	import relpat_pkg::*;

	localparam int    SETTLE_CYCLES = 8;
	localparam int    LONG_HOLD     = 60;
	localparam int    RANDOM_ITEMS  = 290;
	localparam int    MAX_GAP       = 12;
	localparam int    TIMEOUT_NS    = 1_000_000;

	// Local masks not provided by the package
	localparam logic [63:0] HALF_MASK = 64'h0000_0000_0000_FFFF;
	localparam logic [63:0] WORD_MASK = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] PAGE_MASK = ~64'hFFF;

	typedef struct packed {
		logic        [31:0] mode;
		logic        [63:0] sym;
		logic        [63:0] off;
		logic signed [63:0] addend;
		logic        [31:0] word;
	} reloc_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic  [3:0] nbytes;
		logic        bad;
	} patch_result_t;

	logic        clk;
	logic        arst_n;
	logic        load_base_we;
	logic [63:0] load_base_wdata;

	relpat_reloc_if reloc_ch ();
	relpat_patch_if patch_ch ();

	aarch64_relocation_patcher DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.load_base_we    (load_base_we),
		.load_base_wdata (load_base_wdata),
		.reloc           (reloc_ch),
		.patch           (patch_ch)
	);

	reloc_item_t   pending_relocs[$];
	patch_result_t expected_patches[$];
	logic [63:0]   cur_base;
	int            error_count;
	bit            send_gaps_on;
	bit            recv_gaps_on;
	int            hold_requests;
	bit            reloc_taken;
	bit            patch_taken;

	logic [31:0] known_modes [12] = '{R_ABS64, R_ABS32, R_ABS16, R_PREL64, R_PREL32,
		R_PREL16, R_ADR_PG, R_ADD_LO12, R_JUMP26, R_CALL26, R_JUMP_SLOT, R_RELATIVE};

	// Clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Patch computation for one relocation at the given load base
	function automatic patch_result_t compute_patch(input reloc_item_t it,
		input logic [63:0] base);
		patch_result_t r;
		logic [63:0]   sa_sum;
		logic [63:0]   place;
		logic [63:0]   rel;
		logic [63:0]   delta;
		logic [20:0]   imm21;
		logic [31:0]   w;
		sa_sum = it.sym + it.addend;
		place  = base + it.off;
		rel    = sa_sum - place;
		r      = '{value: 64'd0, nbytes: BYTES_NONE, bad: 1'b0};
		case (it.mode)
			R_ABS64, R_JUMP_SLOT, R_RELATIVE: begin
				r.value  = sa_sum;
				r.nbytes = BYTES_DBL;
			end
			R_ABS32: begin
				r.value  = sa_sum & WORD_MASK;
				r.nbytes = BYTES_WORD;
			end
			R_ABS16: begin
				r.value  = sa_sum & HALF_MASK;
				r.nbytes = BYTES_HALF;
			end
			R_PREL64: begin
				r.value  = rel;
				r.nbytes = BYTES_DBL;
			end
			R_PREL32: begin
				r.value  = rel & WORD_MASK;
				r.nbytes = BYTES_WORD;
			end
			R_PREL16: begin
				r.value  = rel & HALF_MASK;
				r.nbytes = BYTES_HALF;
			end
			R_JUMP26, R_CALL26: begin
				w        = (it.word & IMM26_KEEP) | {6'd0, rel[27:2]};
				r.value  = {32'd0, w};
				r.nbytes = BYTES_WORD;
			end
			R_ADR_PG: begin
				delta      = (sa_sum & PAGE_MASK) - (place & PAGE_MASK);
				imm21      = delta[32:12];
				w          = it.word & ADR_KEEP;
				w[30:29]   = imm21[1:0];
				w[23:5]    = imm21[20:2];
				r.value    = {32'd0, w};
				r.nbytes   = BYTES_WORD;
			end
			R_ADD_LO12: begin
				w          = it.word & ADD_KEEP;
				w[21:10]   = sa_sum[11:0];
				r.value    = {32'd0, w};
				r.nbytes   = BYTES_WORD;
			end
			default: begin
				r.bad = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic int draw_gap(input bit on);
		if (!on || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// 64-bit operand biased toward the extremes and small values
	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 6))
			0:       return 64'd0;
			1:       return '1;
			2:       return 64'($urandom_range(0, 4095));
			3:       return {32'hFFFF_FFFF, $urandom};
			4:       return {1'b1, 63'd0} ^ {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_reloc(input logic [31:0] mode, input logic [63:0] sym,
		input logic [63:0] off, input logic [63:0] addend, input logic [31:0] word);
		reloc_item_t it;
		it = '{mode: mode, sym: sym, off: off, addend: addend, word: word};
		pending_relocs.push_back(it);
	endtask

	task automatic queue_random_reloc();
		logic [31:0] mode;
		logic [63:0] off;
		logic [63:0] sym;
		int          pick;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			mode = known_modes[$urandom_range(0, 11)];
		else if (pick == 8)
			mode = 32'($urandom_range(250, 1040));
		else
			mode = $urandom;
		off = rand64();
		sym = rand64();
		// Mostly realistic: symbol near the place, so branch offsets stay in range
		if ($urandom_range(0, 3) != 0) begin
			off = 64'($urandom_range(0, 32'h00FF_FFFF));
			sym = cur_base + off + {{40{$urandom_range(0, 1) == 1}}, 24'($urandom)};
		end
		queue_reloc(mode, sym, off, rand64(), $urandom);
	endtask

	task automatic write_load_base(input logic [63:0] v);
		@(negedge clk);
		load_base_we    <= 1'b1;
		load_base_wdata <= v;
		@(negedge clk);
		load_base_we    <= 1'b0;
		cur_base = v;
	endtask

	// Wait until every queued relocation has been patched and checked
	task automatic drain();
		while (pending_relocs.size() != 0 || expected_patches.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_random_phase(input logic [63:0] base, input bit sgaps,
		input bit rgaps, input bit long_hold);
		write_load_base(base);
		send_gaps_on = sgaps;
		recv_gaps_on = rgaps;
		for (int i = 0; i < RANDOM_ITEMS; i++)
			queue_random_reloc();
		if (long_hold)
			hold_requests++;
		drain();
	endtask

	// Source side: accept capture and expected result
	always @(posedge clk) begin
		reloc_taken = reloc_ch.valid && reloc_ch.ready;
		if (reloc_taken) begin
			expected_patches.push_back(compute_patch(pending_relocs[0], cur_base));
			void'(pending_relocs.pop_front());
		end
	end

	// Source side: drive the next relocation after its gap
	int send_wait;
	always @(negedge clk) begin
		if (!arst_n) begin
			reloc_ch.valid <= 1'b0;
			send_wait = 0;
		end else if (!reloc_ch.valid || reloc_taken) begin
			if (reloc_taken)
				send_wait = draw_gap(send_gaps_on);
			if (send_wait > 0 || pending_relocs.size() == 0) begin
				if (send_wait > 0)
					send_wait--;
				reloc_ch.valid <= 1'b0;
			end else begin
				reloc_ch.valid        <= 1'b1;
				reloc_ch.mode         <= pending_relocs[0].mode;
				reloc_ch.symbol_value <= pending_relocs[0].sym;
				reloc_ch.place_offset <= pending_relocs[0].off;
				reloc_ch.addend       <= pending_relocs[0].addend;
				reloc_ch.old_word     <= pending_relocs[0].word;
			end
		end
	end

	// Sink side: per-result stalls plus the occasional long hold-off
	int recv_wait;
	int hold_left;
	int hold_served;
	always @(negedge clk) begin
		if (!arst_n) begin
			patch_ch.ready <= 1'b0;
			recv_wait   = 0;
			hold_left   = 0;
			hold_served = 0;
		end else begin
			if (patch_taken)
				recv_wait = draw_gap(recv_gaps_on);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				patch_ch.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				patch_ch.ready <= 1'b0;
			end else begin
				patch_ch.ready <= 1'b1;
			end
		end
	end

	// Patch checker
	always @(posedge clk) begin : check_patch
		patch_result_t want;
		patch_taken = patch_ch.valid && patch_ch.ready;
		if (patch_taken) begin
			if (expected_patches.size() == 0) begin
				$display("%0t unexpected patch: expected none, actual value %h bytes %0d bad %b",
					$time, patch_ch.store_value, patch_ch.store_bytes, patch_ch.unhandled);
				error_count++;
			end else begin
				want = expected_patches.pop_front();
				if (patch_ch.store_value !== want.value) begin
					$display("%0t store_value: expected %h actual %h",
						$time, want.value, patch_ch.store_value);
					error_count++;
				end
				if (patch_ch.store_bytes !== want.nbytes) begin
					$display("%0t store_bytes: expected %0d actual %0d",
						$time, want.nbytes, patch_ch.store_bytes);
					error_count++;
				end
				if (patch_ch.unhandled !== want.bad) begin
					$display("%0t unhandled: expected %b actual %b",
						$time, want.bad, patch_ch.unhandled);
					error_count++;
				end
			end
		end
	end

	// Run limit
	initial begin
		#(TIMEOUT_NS);
		$display("tb_aarch64_relocation_patcher NOT OK");
		$finish;
	end

	// Stimulus sequence
	initial begin
		arst_n                = 1'b0;
		load_base_we          = 1'b0;
		load_base_wdata       = 64'd0;
		reloc_ch.valid        = 1'b0;
		reloc_ch.mode         = 32'd0;
		reloc_ch.symbol_value = 64'd0;
		reloc_ch.place_offset = 64'd0;
		reloc_ch.addend       = 64'd0;
		reloc_ch.old_word     = 32'd0;
		patch_ch.ready        = 1'b0;
		cur_base              = 64'd0;
		error_count           = 0;
		hold_requests         = 0;
		send_gaps_on          = 1'b1;
		recv_gaps_on          = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed: every type at reset base, wraparound and unknown types
		queue_reloc(R_ABS64,     64'h0000_0000_0040_1000, 64'h1000, 64'd8, 32'h0);
		queue_reloc(R_ABS32,     64'h1234_5678_9ABC_DEF0, 64'h2000, 64'd4, 32'h0);
		queue_reloc(R_ABS16,     64'h1234_5678_9ABC_DEF0, 64'h2000, -64'sd2, 32'h0);
		queue_reloc(R_PREL64,    64'h0000_0000_0040_0000, 64'h0050_0000, 64'd0, 32'h0);
		queue_reloc(R_PREL32,    64'h0000_0000_0040_0000, 64'h0050_0000, 64'd12, 32'h0);
		queue_reloc(R_PREL16,    64'h0000_0000_0000_8000, 64'h0000_0100, 64'd0, 32'h0);
		queue_reloc(R_ADR_PG,    64'h0000_0000_1234_5678, 64'h0000_1000, 64'd0, 32'h9000_0000);
		queue_reloc(R_ADD_LO12,  64'h0000_0000_1234_5678, 64'h0000_1000, 64'd1, 32'h9100_0000);
		queue_reloc(R_JUMP26,    64'h0000_0000_0000_2000, 64'h0000_1000, 64'd0, 32'h1400_0000);
		queue_reloc(R_CALL26,    64'h0000_0000_0000_0000, 64'h0000_1000, 64'd0, 32'hFFFF_FFFF);
		queue_reloc(R_JUMP_SLOT, 64'h0000_7FFF_0000_0000, 64'h3000, 64'd0, 32'h0);
		queue_reloc(R_RELATIVE,  64'd0, 64'h3008, 64'h0000_0000_0001_0000, 32'h0);
		queue_reloc(R_ABS64,     '1, '1, -64'sd1, '1);
		queue_reloc(R_PREL64,    64'd0, '1, 64'd0, 32'h0);
		queue_reloc(R_JUMP26,    64'd0, 64'd0, {1'b1, 63'd0}, 32'hFFFF_FFFF);
		queue_reloc(R_CALL26,    '1, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
		queue_reloc(R_ADR_PG,    '1, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
		queue_reloc(R_ADR_PG,    64'd0, '1, 64'd0, 32'hFFFF_FFFF);
		queue_reloc(R_ADD_LO12,  64'hFFF, 64'd0, 64'd0, 32'hFFFF_FFFF);
		queue_reloc(32'd0,       '1, '1, -64'sd1, '1);
		queue_reloc(32'hFFFF_FFFF, '1, '1, -64'sd1, '1);
		queue_reloc(32'd256,     64'h1000, 64'h10, 64'd0, 32'h0);
		queue_reloc(32'd276,     64'h1000, 64'h10, 64'd0, 32'h0);
		queue_reloc(32'd1025,    64'h1000, 64'h10, 64'd0, 32'h0);
		queue_reloc(32'd1028,    64'h1000, 64'h10, 64'd0, 32'h0);
		drain();

		// Random phases across load_base settings and traffic shapes
		run_random_phase('1,                      1'b1, 1'b1, 1'b0);
		run_random_phase(64'h0000_0000_0040_0000, 1'b0, 1'b0, 1'b0);
		run_random_phase({$urandom, $urandom},    1'b0, 1'b1, 1'b1);
		run_random_phase(64'd0,                   1'b1, 1'b0, 1'b0);
		run_random_phase({$urandom, $urandom},    1'b1, 1'b1, 1'b1);
		run_random_phase({1'b1, 63'd0},           1'b1, 1'b1, 1'b0);

		if (error_count == 0)
			$display("tb_aarch64_relocation_patcher OK");
		else
			$display("tb_aarch64_relocation_patcher NOT OK");
		$finish;
	end

endmodule
